/* rtl/core/scf_pkg.sv */
// Shared types for the strip cluster finder: cluster result and queue entry layout.
`default_nettype none

package scf_pkg;

  // Packed so that first_strip lands in the lowest bits of the output bus.
  typedef struct packed {
    logic [7:0]  out_plane;
    logic [6:0]  out_layer;
    logic [23:0] energy_sum;
    logic [8:0]  cluster_width;
    logic [7:0]  peak_strip;
    logic [7:0]  final_strip;
    logic [7:0]  first_strip;
  } result_t;

  typedef struct packed {
    logic    last;
    result_t res;
  } entry_t;

  // Up to two results leave the cluster stage per hit, first one in order first.
  typedef struct packed {
    logic   first_valid;
    logic   second_valid;
    entry_t first;
    entry_t second;
  } push_t;

  localparam int unsigned WIDTH_MAX = 511;

endpackage

`default_nettype wire

/* rtl/core/strip_cluster_finder.sv */
// Strip cluster finder top level: stream ports around the cluster stage and result queue.
//
// Usage:
//   Slave stream carries strip hits of a layer in ascending strip order; tlast marks
//   the final hit of a layer. Consecutive strips of one layer form a cluster; a gap,
//   a layer change or the end-of-layer mark closes it.
//   Master stream carries one closed cluster per request; tlast marks the final
//   cluster caused by one hit (a hit can close the running cluster and, with the
//   end-of-layer mark, report its own one-hit cluster as a second request).
//   A hit that closes a cluster passes the input register and is written into the
//   queue, from whose head its first result is put on the master stream.
//   Throughput: one hit per cycle while the queue has room, taken by the compare and
//   add of the cluster stage; results leave at one per cycle while tready is high,
//   through a four-entry queue, so a hit that yields two results is handed out as two
//   requests, and the input stalls only while the queue holds more than two results.
//   Stall: when the receiver holds tready low, the queue fills; the input register
//   holds its hit and s_axis_tready_o drops once the queue can no longer take two.
//   Reset: clears the open cluster, the input register and the queue; no clearing
//   pass is needed and a hit can be taken as soon as reset is released.
`default_nettype none

module strip_cluster_finder #(
  parameter int unsigned STRIP_COUNT = 256,
  parameter int unsigned ENERGY_BITS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // strip[7:0], energy[23:8], layer_id[30:24], plane_id[38:31], zero pad[39]
  input  wire logic [39:0]  s_axis_tdata_i,
  // layer_end
  input  wire logic         s_axis_tlast_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // first_strip[7:0], final_strip[15:8], peak_strip[23:16], cluster_width[32:24],
  // energy_sum[56:33], out_layer[63:57], out_plane[71:64]
  output logic [71:0]       m_axis_tdata_o,
  // last_result
  output logic              m_axis_tlast_o
);

  scf_pkg::push_t  push;
  scf_pkg::entry_t head;
  logic            room;

  scf_cluster #(
    .STRIP_COUNT (STRIP_COUNT),
    .ENERGY_BITS (ENERGY_BITS)
  ) u_cluster (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_strip_i  (s_axis_tdata_i[7:0]),
    .in_energy_i (s_axis_tdata_i[23:8]),
    .in_layer_i  (s_axis_tdata_i[30:24]),
    .in_plane_i  (s_axis_tdata_i[38:31]),
    .in_end_i    (s_axis_tlast_i),
    .room_i      (room),
    .push_o      (push)
  );

  scf_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_entry_o (head)
  );

  assign m_axis_tdata_o = head.res;
  assign m_axis_tlast_o = head.last;

endmodule

`default_nettype wire

/* rtl/core/scf_cluster.sv */
// Input register and cluster build logic: one registered hit per cycle while the queue has room, up to two results.
`default_nettype none

module scf_cluster #(
  parameter int unsigned STRIP_COUNT = 256,
  parameter int unsigned ENERGY_BITS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [7:0]   in_strip_i,
  input  wire logic [15:0]  in_energy_i,
  input  wire logic [6:0]   in_layer_i,
  input  wire logic [7:0]   in_plane_i,
  input  wire logic         in_end_i,
  input  wire logic         room_i,
  output scf_pkg::push_t    push_o
);

  localparam int unsigned EKEEP = (ENERGY_BITS < 16) ? ENERGY_BITS : 16;
  localparam logic [15:0] EMASK = 16'((64'd1 << EKEEP) - 64'd1);

  // Input register
  logic        v_q;
  logic [7:0]  strip_q;
  logic [15:0] energy_q;
  logic [6:0]  layer_q;
  logic [7:0]  plane_q;
  logic        end_q;

  // Cluster state
  logic        open_q, open_d;
  logic [7:0]  start_q, start_d;
  logic [7:0]  prev_q, prev_d;
  logic [7:0]  best_strip_q, best_strip_d;
  logic [15:0] best_energy_q, best_energy_d;
  logic [8:0]  run_width_q, run_width_d;
  logic [23:0] run_energy_q, run_energy_d;
  logic [6:0]  held_layer_q, held_layer_d;
  logic [7:0]  held_plane_q, held_plane_d;

  logic        advance;
  logic        load;
  logic        in_range;
  logic        split;
  logic        grow;
  logic [15:0] ev;
  logic [24:0] sum_ext;
  scf_pkg::result_t cur_res;
  scf_pkg::result_t nxt_res;

  assign advance    = v_q && room_i;
  assign in_ready_o = !v_q || room_i;
  assign load       = in_valid_i && in_ready_o;

  assign ev       = energy_q & EMASK;
  assign in_range = 32'(strip_q) < STRIP_COUNT;
  assign split    = open_q && ((layer_q != held_layer_q) ||
                               ({1'b0, strip_q} != ({1'b0, prev_q} + 9'd1)));
  assign grow     = open_q && !split;
  assign sum_ext  = {1'b0, run_energy_q} + {9'b0, ev};

  always_comb begin
    if (grow) begin
      start_d      = start_q;
      prev_d       = strip_q;
      held_layer_d = held_layer_q;
      held_plane_d = plane_q;
      if (ev > best_energy_q) begin
        best_energy_d = ev;
        best_strip_d  = strip_q;
      end else begin
        best_energy_d = best_energy_q;
        best_strip_d  = best_strip_q;
      end
      if (run_width_q == 9'(scf_pkg::WIDTH_MAX)) begin
        run_width_d = run_width_q;
      end else begin
        run_width_d = run_width_q + 9'd1;
      end
      run_energy_d = sum_ext[24] ? 24'hFF_FFFF : sum_ext[23:0];
    end else begin
      start_d       = strip_q;
      prev_d        = strip_q;
      held_layer_d  = layer_q;
      held_plane_d  = plane_q;
      best_energy_d = ev;
      best_strip_d  = strip_q;
      run_width_d   = 9'd1;
      run_energy_d  = {8'b0, ev};
    end
  end

  always_comb begin
    if (in_range) begin
      open_d = !end_q;
    end else if (end_q) begin
      open_d = 1'b0;
    end else begin
      open_d = open_q;
    end
  end

  always_comb begin
    cur_res.first_strip   = start_q;
    cur_res.final_strip   = prev_q;
    cur_res.peak_strip    = best_strip_q;
    cur_res.cluster_width = run_width_q;
    cur_res.energy_sum    = run_energy_q;
    cur_res.out_layer     = held_layer_q;
    cur_res.out_plane     = held_plane_q;

    nxt_res.first_strip   = start_d;
    nxt_res.final_strip   = prev_d;
    nxt_res.peak_strip    = best_strip_d;
    nxt_res.cluster_width = run_width_d;
    nxt_res.energy_sum    = run_energy_d;
    nxt_res.out_layer     = held_layer_d;
    nxt_res.out_plane     = held_plane_d;
  end

  // Closed cluster goes first; a hit that both splits and ends the layer adds its own.
  always_comb begin
    push_o.first_valid  = advance && (in_range ? (split || end_q) : (end_q && open_q));
    push_o.second_valid = advance && in_range && split && end_q;
    push_o.first.res    = (!in_range || split) ? cur_res : nxt_res;
    push_o.first.last   = !(in_range && split && end_q);
    push_o.second.res   = nxt_res;
    push_o.second.last  = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (load) begin
      v_q <= 1'b1;
    end else if (advance) begin
      v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      strip_q  <= in_strip_i;
      energy_q <= in_energy_i;
      layer_q  <= in_layer_i;
      plane_q  <= in_plane_i;
      end_q    <= in_end_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q        <= 1'b0;
      start_q       <= '0;
      prev_q        <= '0;
      best_strip_q  <= '0;
      best_energy_q <= '0;
      run_width_q   <= '0;
      run_energy_q  <= '0;
      held_layer_q  <= '0;
      held_plane_q  <= '0;
    end else if (advance) begin
      open_q <= open_d;
      if (in_range) begin
        start_q       <= start_d;
        prev_q        <= prev_d;
        best_strip_q  <= best_strip_d;
        best_energy_q <= best_energy_d;
        run_width_q   <= run_width_d;
        run_energy_q  <= run_energy_d;
        held_layer_q  <= held_layer_d;
        held_plane_q  <= held_plane_d;
      end
    end
  end

  a_second_needs_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.second_valid |-> push_o.first_valid)
    else $error("second result pushed without a first");

  a_end_closes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && end_q) |=> !open_q)
    else $error("cluster left open after end of layer");

endmodule

`default_nettype wire

/* rtl/core/scf_out_fifo.sv */
// Result queue: takes up to two results per cycle, hands out one per cycle while the receiver is ready.
`default_nettype none

module scf_out_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire scf_pkg::push_t push_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output scf_pkg::entry_t    out_entry_o
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  scf_pkg::entry_t    mem [DEPTH];
  logic [PTR_W-1:0]   wr_q, wr_d;
  logic [PTR_W-1:0]   rd_q, rd_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               pop;

  assign out_valid_o = count_q != '0;
  assign out_entry_o = mem[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  // Room for a worst-case pair, whatever the receiver does this cycle.
  assign room_o      = count_q <= CNT_W'(DEPTH - 2);

  always_comb begin
    wr_d    = wr_q + PTR_W'(push_i.first_valid) + PTR_W'(push_i.second_valid);
    rd_d    = rd_q + PTR_W'(pop);
    count_d = count_q + CNT_W'(push_i.first_valid) + CNT_W'(push_i.second_valid)
              - CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.first_valid) begin
      mem[wr_q] <= push_i.first;
    end
    if (push_i.second_valid) begin
      mem[wr_q + PTR_W'(1)] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  a_no_overfill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("result queue over capacity");

  a_push_with_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.first_valid |-> (count_q <= CNT_W'(DEPTH - 2)))
    else $error("push into queue without room for a pair");

endmodule

`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for the strip cluster finder: directed and random hit streams with a scoreboard.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned STRIP_COUNT = 256;
  localparam int unsigned ENERGY_BITS = 16;
  localparam int unsigned HIT_TARGET  = 1600;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned HOLD_AT     = 200;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    logic        layer_end;
    logic [7:0]  plane_id;
    logic [6:0]  layer_id;
    logic [15:0] energy;
    logic [7:0]  strip;
  } hit_t;

  class cluster_scoreboard;
    scf_pkg::entry_t clusters_due[$];
    scf_pkg::entry_t fresh[$];
    int unsigned     errors;

    // Running cluster
    logic        open;
    logic [7:0]  first_strip;
    logic [7:0]  prev_strip;
    logic [7:0]  peak_strip;
    logic [15:0] peak_energy;
    logic [8:0]  width;
    logic [23:0] energy_sum;
    logic [6:0]  layer;
    logic [7:0]  plane;

    function new();
      errors      = 0;
      open        = 1'b0;
      first_strip = '0;
      prev_strip  = '0;
      peak_strip  = '0;
      peak_energy = '0;
      width       = '0;
      energy_sum  = '0;
      layer       = '0;
      plane       = '0;
    endfunction

    function void close_cluster();
      scf_pkg::entry_t ent;
      ent.last              = 1'b0;
      ent.res.first_strip   = first_strip;
      ent.res.final_strip   = prev_strip;
      ent.res.peak_strip    = peak_strip;
      ent.res.cluster_width = width;
      ent.res.energy_sum    = energy_sum;
      ent.res.out_layer     = layer;
      ent.res.out_plane     = plane;
      fresh.insert(fresh.size(), ent);
      open = 1'b0;
    endfunction

    function void note_hit(hit_t h);
      logic [15:0] e;
      logic [24:0] wide_sum;
      e = h.energy & 16'((64'd1 << ENERGY_BITS) - 64'd1);
      fresh.delete();
      if (int'(h.strip) >= int'(STRIP_COUNT)) begin
        if (h.layer_end && open) close_cluster();
      end else begin
        // A gap includes a repeated or lower strip, and 255 followed by 0.
        if (open && (h.layer_id != layer || {1'b0, h.strip} != {1'b0, prev_strip} + 9'd1))
          close_cluster();
        if (open) begin
          prev_strip = h.strip;
          plane      = h.plane_id;
          if (e > peak_energy) begin
            peak_energy = e;
            peak_strip  = h.strip;
          end
          if (width < scf_pkg::WIDTH_MAX) width = width + 9'd1;
          wide_sum = {1'b0, energy_sum} + {9'd0, e};
          energy_sum = (wide_sum > 25'hFFFFFF) ? 24'hFFFFFF : wide_sum[23:0];
        end else begin
          open        = 1'b1;
          first_strip = h.strip;
          prev_strip  = h.strip;
          peak_strip  = h.strip;
          peak_energy = e;
          width       = 9'd1;
          energy_sum  = {8'd0, e};
          layer       = h.layer_id;
          plane       = h.plane_id;
        end
        if (h.layer_end) close_cluster();
      end
      if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
      foreach (fresh[i]) clusters_due.insert(clusters_due.size(), fresh[i]);
    endfunction

    function void compare_field(string name, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
        $error("%s: expected %0d, got %0d", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_cluster(logic [71:0] data, logic last);
      scf_pkg::entry_t exp_ent;
      scf_pkg::result_t got;
      got = scf_pkg::result_t'(data);
      if (clusters_due.size() == 0) begin
        $error("cluster result with none expected: first_strip %0d", got.first_strip);
        errors++;
      end else begin
        exp_ent = clusters_due.pop_front();
        compare_field("first_strip", exp_ent.res.first_strip, got.first_strip);
        compare_field("final_strip", exp_ent.res.final_strip, got.final_strip);
        compare_field("peak_strip", exp_ent.res.peak_strip, got.peak_strip);
        compare_field("cluster_width", exp_ent.res.cluster_width, got.cluster_width);
        compare_field("energy_sum", exp_ent.res.energy_sum, got.energy_sum);
        compare_field("out_layer", exp_ent.res.out_layer, got.out_layer);
        compare_field("out_plane", exp_ent.res.out_plane, got.out_plane);
        compare_field("last_result", exp_ent.last, last);
      end
    endfunction

    function int pending();
      return clusters_due.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        hit_valid;
  logic        hit_ready;
  logic [39:0] hit_data;
  logic        hit_last;
  logic        clus_valid;
  logic        clus_ready;
  logic [71:0] clus_data;
  logic        clus_last;

  cluster_scoreboard sb;
  hit_t              hits[$];
  int unsigned       cycles = 0;
  int unsigned       clusters_seen;

  strip_cluster_finder #(
    .STRIP_COUNT(STRIP_COUNT),
    .ENERGY_BITS(ENERGY_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(hit_valid),
    .s_axis_tready_o(hit_ready),
    .s_axis_tdata_i (hit_data),
    .s_axis_tlast_i (hit_last),
    .m_axis_tvalid_o(clus_valid),
    .m_axis_tready_i(clus_ready),
    .m_axis_tdata_o (clus_data),
    .m_axis_tlast_o (clus_last)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic hit_t mk_hit(int strip, int energy, int layer, int plane, bit last);
    hit_t h;
    h.strip     = 8'(strip);
    h.energy    = 16'(energy);
    h.layer_id  = 7'(layer);
    h.plane_id  = 8'(plane);
    h.layer_end = last;
    return h;
  endfunction

  function automatic int draw_energy();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 16'hFFFF;
      2:       return $urandom_range(0, 3);
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  // Offer one hit; the gap before it is skipped in burst mode.
  task automatic send_hit(hit_t h, bit burst);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      hit_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    hit_valid <= 1'b1;
    hit_data  <= {1'b0, h.plane_id, h.layer_id, h.energy, h.strip};
    hit_last  <= h.layer_end;
    do @(posedge clk_i); while (!hit_ready);
    sb.note_hit(h);
  endtask

  // Take one cluster request, stalling first for the drawn number of cycles.
  task automatic take_cluster(int unsigned stall);
    if (stall > 0) begin
      clus_ready <= 1'b0;
      repeat (stall) @(posedge clk_i);
    end
    clus_ready <= 1'b1;
    do @(posedge clk_i); while (!clus_valid);
    sb.check_cluster(clus_data, clus_last);
    clusters_seen++;
  endtask

  initial begin
    bit          rx_burst;
    int unsigned stall;
    clus_ready    <= 1'b0;
    clusters_seen = 0;
    rx_burst      = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (clusters_seen % 40 == 0) rx_burst = ($urandom_range(0, 2) == 0);
      stall = rx_burst ? 0 : $urandom_range(0, 4);
      // Hold off for a long stretch once so the queue fills and the input stalls.
      if (clusters_seen == HOLD_AT) stall = HOLD_CYCLES;
      take_cluster(stall);
    end
  end

  initial begin
    bit full_done;
    int full_at;
    int r;
    int lay;
    int pln;
    int s;
    int len;
    int step;
    bit tx_burst;

    hit_valid <= 1'b0;
    hit_data  <= '0;
    hit_last  <= 1'b0;
    rst_ni    <= 1'b0;
    sb        = new();

    // Extremes and lone hits
    hits.insert(hits.size(), mk_hit(0, 0, 0, 0, 1));
    hits.insert(hits.size(), mk_hit(255, 16'hFFFF, 127, 255, 1));
    // Peak tie: first of the equal strips wins
    hits.insert(hits.size(), mk_hit(10, 5, 1, 2, 0));
    hits.insert(hits.size(), mk_hit(11, 9, 1, 2, 0));
    hits.insert(hits.size(), mk_hit(12, 9, 1, 2, 1));
    // Gap closes the run, then a fresh one
    hits.insert(hits.size(), mk_hit(20, 100, 2, 3, 0));
    hits.insert(hits.size(), mk_hit(21, 200, 2, 3, 0));
    hits.insert(hits.size(), mk_hit(30, 300, 2, 3, 0));
    hits.insert(hits.size(), mk_hit(31, 50, 2, 3, 1));
    // Repeated and lower strips count as gaps
    hits.insert(hits.size(), mk_hit(40, 7, 3, 4, 0));
    hits.insert(hits.size(), mk_hit(40, 8, 3, 4, 0));
    hits.insert(hits.size(), mk_hit(39, 9, 3, 4, 1));
    // Gap together with the end mark gives two results
    hits.insert(hits.size(), mk_hit(60, 11, 4, 5, 0));
    hits.insert(hits.size(), mk_hit(70, 12, 4, 5, 1));
    // Layer change on an adjacent strip, with the end mark
    hits.insert(hits.size(), mk_hit(80, 13, 5, 6, 0));
    hits.insert(hits.size(), mk_hit(81, 14, 6, 6, 1));
    // Plane change inside a layer keeps the cluster
    hits.insert(hits.size(), mk_hit(90, 1, 7, 1, 0));
    hits.insert(hits.size(), mk_hit(91, 3, 7, 2, 0));
    hits.insert(hits.size(), mk_hit(92, 2, 7, 3, 1));
    // All-zero energies peak at the first strip
    hits.insert(hits.size(), mk_hit(100, 0, 8, 9, 0));
    hits.insert(hits.size(), mk_hit(101, 0, 8, 9, 0));
    hits.insert(hits.size(), mk_hit(102, 0, 8, 9, 1));
    // Strip 255 followed by 0 is not adjacent
    hits.insert(hits.size(), mk_hit(254, 20, 9, 10, 0));
    hits.insert(hits.size(), mk_hit(255, 21, 9, 10, 0));
    hits.insert(hits.size(), mk_hit(0, 22, 9, 10, 1));

    full_done = 1'b0;
    full_at   = $urandom_range(300, 1200);
    while (hits.size() < HIT_TARGET) begin
      r = $urandom_range(0, 99);
      if (!full_done && hits.size() >= full_at) begin
        // Whole layer at full energy: widest cluster and largest sum
        full_done = 1'b1;
        lay = $urandom_range(0, 127);
        pln = $urandom_range(0, 255);
        for (int k = 0; k < 256; k++)
          hits.insert(hits.size(), mk_hit(k, 16'hFFFF, lay, pln, k == 255));
      end else if (r < 12) begin
        hits.insert(hits.size(),
                    mk_hit($urandom_range(0, 255), draw_energy(), $urandom_range(0, 127),
                           $urandom_range(0, 255), $urandom_range(0, 3) == 0));
      end else begin
        lay = $urandom_range(0, 127);
        pln = $urandom_range(0, 255);
        s   = $urandom_range(0, 255);
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          if (k > 0) begin
            step = ($urandom_range(0, 3) != 0) ? 1 : $urandom_range(0, 6);
            if (s + step > 255) break;
            s = s + step;
            if ($urandom_range(0, 7) == 0) pln = $urandom_range(0, 255);
          end
          hits.insert(hits.size(), mk_hit(s, draw_energy(), lay, pln, 1'b0));
        end
        // Mostly end the layer by its mark; otherwise the next layer closes it.
        hits[hits.size() - 1].layer_end = ($urandom_range(0, 9) != 0);
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_burst = 1'b0;
    foreach (hits[i]) begin
      if (i % 50 == 0) tx_burst = ($urandom_range(0, 2) == 0);
      send_hit(hits[i], tx_burst);
    end
    hit_valid <= 1'b0;
    hit_last  <= 1'b0;

    while (sb.pending() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/scf_pkg.sv
rtl/core/scf_cluster.sv
rtl/core/scf_out_fifo.sv
rtl/core/strip_cluster_finder.sv
test/tb.sv
